@@ rtl/text_mode_screen_engine_defines.svh @@
// Assertion macros for the text mode screen engine.
// Included by the top level; no other dependencies.
`ifndef TEXT_MODE_SCREEN_ENGINE_DEFINES_SVH
`define TEXT_MODE_SCREEN_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define TMSE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TMSE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TMSE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TMSE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/tmse_pkg.sv @@
// Shared types and constants of the text mode screen engine.
// No dependencies.
package tmse_pkg;

   localparam int MAX_COLS_DEF = 80;
   localparam int MAX_ROWS_DEF = 25;
   localparam int PAGES_DEF    = 8;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_W      = 7;

   // opcodes
   localparam logic [2:0] OP_SET_CURSOR  = 3'd0;
   localparam logic [2:0] OP_TELETYPE    = 3'd1;
   localparam logic [2:0] OP_SCROLL_UP   = 3'd2;
   localparam logic [2:0] OP_SCROLL_DOWN = 3'd3;
   localparam logic [2:0] OP_READ_CELL   = 3'd4;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_BAD_OP = 2'd2;

   // register indexes
   localparam logic CSR_COLS = 1'b0;
   localparam logic CSR_ROWS = 1'b1;

   // teletype control characters
   localparam logic [7:0]  CH_BS    = 8'h08;
   localparam logic [7:0]  CH_CR    = 8'h0D;
   localparam logic [7:0]  CH_LF    = 8'h0A;
   localparam logic [7:0]  CH_BEL   = 8'h07;
   localparam logic [15:0] TTY_FILL = 16'h0720;

   typedef enum logic [2:0] {
      K_BAD_PAGE,
      K_BAD_OP,
      K_SET_CURSOR,
      K_TELETYPE,
      K_SCROLL,
      K_REJECT,
      K_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   page;
      logic [7:0]   ch;
      logic [7:0]   attr;
      logic [7:0]   set_col;
      logic [7:0]   set_row;
      logic [7:0]   cm1;
      logic [7:0]   rm1;
      logic [7:0]   left;
      logic [7:0]   top;
      logic [7:0]   right;
      logic [7:0]   bottom;
      logic [7:0]   count;
      logic         up;
      logic         fill_all;
   } cmd_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic [6:0] col;
      logic [4:0] row;
      logic       scrolled;
      logic [1:0] status;
   } res_type;

   typedef enum logic [2:0] {
      BS_CLEAR,
      BS_IDLE,
      BS_EXEC,
      BS_READ_WAIT,
      BS_WALK,
      BS_WALK_WR,
      BS_DONE
   } back_state_type;

endpackage

@@ rtl/tmse_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module tmse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16000
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/tmse_queue.sv @@
// Two-entry command queue between front and back.
// Depends on tmse_pkg.
module tmse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tmse_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output tmse_pkg::cmd_type pop_cmd
);
   import tmse_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

@@ rtl/tmse_front.sv @@
// Front end: mode registers, request intake, clamping and classification.
// Depends on tmse_pkg.
module tmse_front #(
   parameter int MAX_COLS = tmse_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tmse_pkg::MAX_ROWS_DEF,
   parameter int PAGES    = tmse_pkg::PAGES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [tmse_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [2:0]                     req_tuser,
   input  logic [tmse_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           clearing,
   input  logic                           q_full,
   output logic                           q_push,
   output tmse_pkg::cmd_type              q_cmd
);
   import tmse_pkg::*;

   logic [6:0] cols_ff;
   logic [4:0] rows_ff;
   logic [7:0] c_eff, r_eff, cm1, rm1;
   logic [7:0] page8, ccol, crow, cnt, lft, tp, rgt, bot;
   logic [7:0] rgt_c, bot_c, height;
   logic       reject;

   // mode registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= 7'd80;
         rows_ff <= 5'd25;
      end else if (csr_we) begin
         if (csr_index == CSR_COLS) begin
            cols_ff <= csr_wdata;
         end else begin
            rows_ff <= 5'(csr_wdata);
         end
      end
   end

   assign req_tready = !q_full && !clearing;
   assign q_push     = req_tvalid && req_tready;

   // clamp and classify the beat
   always_comb begin
      c_eff = (cols_ff == 7'd0) ? 8'd1 :
              ({1'b0, cols_ff} > 8'(MAX_COLS)) ? 8'(MAX_COLS) : {1'b0, cols_ff};
      r_eff = (rows_ff == 5'd0) ? 8'd1 :
              ({3'b0, rows_ff} > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : {3'b0, rows_ff};
      cm1   = c_eff - 8'd1;
      rm1   = r_eff - 8'd1;
      page8 = {5'b0, req_tdata[2:0]};
      ccol  = req_tdata[26:19];
      crow  = req_tdata[34:27];
      cnt   = req_tdata[42:35];
      lft   = req_tdata[50:43];
      tp    = req_tdata[58:51];
      rgt   = req_tdata[66:59];
      bot   = req_tdata[74:67];
      rgt_c = (rgt > cm1) ? cm1 : rgt;
      bot_c = (bot > rm1) ? rm1 : bot;
      reject = (lft > rgt_c) || (tp > bot_c);
      height = bot_c - tp + 8'd1;

      q_cmd          = '0;
      q_cmd.page     = req_tdata[2:0];
      q_cmd.ch       = req_tdata[10:3];
      q_cmd.attr     = req_tdata[18:11];
      q_cmd.set_col  = (ccol > cm1) ? cm1 : ccol;
      q_cmd.set_row  = (crow > rm1) ? rm1 : crow;
      q_cmd.cm1      = cm1;
      q_cmd.rm1      = rm1;
      q_cmd.left     = lft;
      q_cmd.top      = tp;
      q_cmd.right    = rgt_c;
      q_cmd.bottom   = bot_c;
      q_cmd.count    = cnt;
      q_cmd.up       = (req_tuser == OP_SCROLL_UP);
      q_cmd.fill_all = (cnt == 8'd0) || (cnt >= height);

      if ({1'b0, page8} >= 9'(PAGES)) begin
         q_cmd.kind = K_BAD_PAGE;
      end else begin
         case (req_tuser)
            OP_SET_CURSOR:  q_cmd.kind = K_SET_CURSOR;
            OP_TELETYPE:    q_cmd.kind = K_TELETYPE;
            OP_SCROLL_UP,
            OP_SCROLL_DOWN: q_cmd.kind = reject ? K_REJECT : K_SCROLL;
            OP_READ_CELL:   q_cmd.kind = K_READ;
            default:        q_cmd.kind = K_BAD_OP;
         endcase
      end
   end
endmodule

@@ rtl/tmse_back.sv @@
// Back end: cursor store, screen RAM sequencer and result register.
// Depends on tmse_pkg and tmse_ram.
module tmse_back #(
   parameter int MAX_COLS = tmse_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tmse_pkg::MAX_ROWS_DEF,
   parameter int PAGES    = tmse_pkg::PAGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  tmse_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tmse_pkg::res_type rsp_res
);
   import tmse_pkg::*;

   localparam int CELLS = PAGES * MAX_ROWS * MAX_COLS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PIW   = (PAGES > 1) ? $clog2(PAGES) : 1;

   function automatic logic [AW-1:0] cell_addr(input logic [2:0] pg, input logic [7:0] rw,
                                               input logic [7:0] cl);
      cell_addr = AW'(32'(pg) * (MAX_ROWS * MAX_COLS) + 32'(rw) * MAX_COLS + 32'(cl));
   endfunction

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   cmd_type        cmd_ff, cmd_in;
   res_type        res_ff, res_in;
   res_type        out_ff, out_in;
   logic           out_valid_ff, out_valid_in;
   logic [7:0]     cur_col_ff [PAGES];
   logic [7:0]     cur_row_ff [PAGES];
   logic           cur_we;
   logic [7:0]     cur_wcol, cur_wrow;

   // walk descriptor
   logic [2:0]  d_page_ff, d_page_in;
   logic [7:0]  d_left_ff, d_left_in, d_right_ff, d_right_in;
   logic [7:0]  d_top_ff, d_top_in, d_bot_ff, d_bot_in, d_n_ff, d_n_in;
   logic        d_up_ff, d_up_in, d_all_ff, d_all_in;
   logic [15:0] d_fill_ff, d_fill_in;
   logic [7:0]  row_ff, row_in, col_ff, col_in;

   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [15:0]     ram_wdata, ram_rdata;

   logic [PIW-1:0] pidx;
   logic [7:0]     cc, cr, t_col, t_row, src_row;
   logic           t_write, t_scroll, do_copy, last_col, last_row;

   tmse_ram #(.WIDTH(16), .DEPTH(CELLS)) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign clearing  = (state_ff == BS_CLEAR);
   assign rsp_valid = out_valid_ff;
   assign rsp_res   = out_ff;

   // clamp the stored cursor and work out the teletype move
   always_comb begin
      pidx     = PIW'(cmd_ff.page);
      cc       = (cur_col_ff[pidx] > cmd_ff.cm1) ? cmd_ff.cm1 : cur_col_ff[pidx];
      cr       = (cur_row_ff[pidx] > cmd_ff.rm1) ? cmd_ff.rm1 : cur_row_ff[pidx];
      t_col    = cc;
      t_row    = cr;
      t_write  = 1'b0;
      t_scroll = 1'b0;
      case (cmd_ff.ch)
         CH_BS: begin
            if (cc != 8'd0) begin
               t_col = cc - 8'd1;
            end else if (cr != 8'd0) begin
               t_row = cr - 8'd1;
               t_col = cmd_ff.cm1;
            end
         end
         CH_CR: t_col = 8'd0;
         CH_LF: begin
            t_col = 8'd0;
            if (cr == cmd_ff.rm1) begin
               t_scroll = 1'b1;
            end else begin
               t_row = cr + 8'd1;
            end
         end
         CH_BEL: t_write = 1'b0;
         default: begin
            t_write = 1'b1;
            if (cc == cmd_ff.cm1) begin
               t_col = 8'd0;
               if (cr == cmd_ff.rm1) begin
                  t_scroll = 1'b1;
               end else begin
                  t_row = cr + 8'd1;
               end
            end else begin
               t_col = cc + 8'd1;
            end
         end
      endcase
   end

   // walk geometry
   always_comb begin
      if (d_up_ff) begin
         do_copy  = !d_all_ff && ({1'b0, row_ff} + {1'b0, d_n_ff} <= {1'b0, d_bot_ff});
         src_row  = row_ff + d_n_ff;
         last_row = (row_ff == d_bot_ff);
      end else begin
         do_copy  = !d_all_ff && ({1'b0, row_ff} >= {1'b0, d_top_ff} + {1'b0, d_n_ff});
         src_row  = row_ff - d_n_ff;
         last_row = (row_ff == d_top_ff);
      end
      last_col = (col_ff == d_right_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      d_page_in    = d_page_ff;
      d_left_in    = d_left_ff;
      d_right_in   = d_right_ff;
      d_top_in     = d_top_ff;
      d_bot_in     = d_bot_ff;
      d_n_in       = d_n_ff;
      d_up_in      = d_up_ff;
      d_all_in     = d_all_ff;
      d_fill_in    = d_fill_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      q_pop        = 1'b0;
      cur_we       = 1'b0;
      cur_wcol     = cmd_ff.set_col;
      cur_wrow     = cmd_ff.set_row;
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(d_page_ff, row_ff, col_ff);
      ram_wdata    = d_fill_ff;
      ram_re       = 1'b0;
      ram_raddr    = cell_addr(d_page_ff, src_row, col_ff);

      // drop the result once taken
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         BS_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 16'h0000;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = BS_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         BS_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = BS_EXEC;
            end
         end
         BS_EXEC: begin
            res_in     = '0;
            res_in.col = 7'(cc);
            res_in.row = 5'(cr);
            state_in   = BS_DONE;
            d_page_in  = cmd_ff.page;
            case (cmd_ff.kind)
               K_BAD_PAGE: res_in = '0;
               K_BAD_OP:   res_in.status = ST_BAD_OP;
               K_REJECT:   res_in.status = ST_REJECT;
               K_SET_CURSOR: begin
                  cur_we     = 1'b1;
                  res_in.col = 7'(cmd_ff.set_col);
                  res_in.row = 5'(cmd_ff.set_row);
               end
               K_READ: begin
                  ram_re    = 1'b1;
                  ram_raddr = cell_addr(cmd_ff.page, cr, cc);
                  state_in  = BS_READ_WAIT;
               end
               K_SCROLL: begin
                  d_left_in  = cmd_ff.left;
                  d_right_in = cmd_ff.right;
                  d_top_in   = cmd_ff.top;
                  d_bot_in   = cmd_ff.bottom;
                  d_n_in     = cmd_ff.count;
                  d_up_in    = cmd_ff.up;
                  d_all_in   = cmd_ff.fill_all;
                  d_fill_in  = {cmd_ff.attr, 8'h00};
                  row_in     = cmd_ff.up ? cmd_ff.top : cmd_ff.bottom;
                  col_in     = cmd_ff.left;
                  state_in   = BS_WALK;
               end
               K_TELETYPE: begin
                  cur_we          = 1'b1;
                  cur_wcol        = t_col;
                  cur_wrow        = t_row;
                  res_in.col      = 7'(t_col);
                  res_in.row      = 5'(t_row);
                  res_in.scrolled = t_scroll;
                  if (t_write) begin
                     ram_we    = 1'b1;
                     ram_waddr = cell_addr(cmd_ff.page, cr, cc);
                     ram_wdata = {cmd_ff.attr, cmd_ff.ch};
                  end
                  if (t_scroll) begin
                     d_left_in  = 8'd0;
                     d_right_in = cmd_ff.cm1;
                     d_top_in   = 8'd0;
                     d_bot_in   = cmd_ff.rm1;
                     d_n_in     = 8'd1;
                     d_up_in    = 1'b1;
                     d_all_in   = (cmd_ff.rm1 == 8'd0);
                     d_fill_in  = TTY_FILL;
                     row_in     = 8'd0;
                     col_in     = 8'd0;
                     state_in   = BS_WALK;
                  end
               end
               default: res_in = '0;
            endcase
         end
         BS_READ_WAIT: begin
            res_in.cell_char = ram_rdata[7:0];
            res_in.cell_attr = ram_rdata[15:8];
            state_in         = BS_DONE;
         end
         BS_WALK, BS_WALK_WR: begin
            if (state_ff == BS_WALK && do_copy) begin
               ram_re   = 1'b1;
               state_in = BS_WALK_WR;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = (state_ff == BS_WALK_WR) ? ram_rdata : d_fill_ff;
               state_in  = BS_WALK;
               // advance to the next cell
               if (last_col) begin
                  col_in = d_left_ff;
                  if (last_row) begin
                     state_in = BS_DONE;
                  end else begin
                     row_in = d_up_ff ? row_ff + 8'd1 : row_ff - 8'd1;
                  end
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         BS_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_in       = res_ff;
               state_in     = BS_IDLE;
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // cursor store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGES; i++) begin
            cur_col_ff[i] <= 8'd0;
            cur_row_ff[i] <= 8'd0;
         end
      end else if (cur_we) begin
         cur_col_ff[pidx] <= cur_wcol;
         cur_row_ff[pidx] <= cur_wrow;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      d_page_ff  <= d_page_in;
      d_left_ff  <= d_left_in;
      d_right_ff <= d_right_in;
      d_top_ff   <= d_top_in;
      d_bot_ff   <= d_bot_in;
      d_n_ff     <= d_n_in;
      d_up_ff    <= d_up_in;
      d_all_ff   <= d_all_in;
      d_fill_ff  <= d_fill_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
   end
endmodule

@@ rtl/text_mode_screen_engine.sv @@
// Text mode screen engine top level: front end, command queue and back end.
// Depends on tmse_pkg, tmse_front, tmse_queue, tmse_back and the defines header.
//
// Paged text screen with a cursor per page. After reset the screen RAM is
// swept to zero, one cell a cycle, over all PAGES*MAX_ROWS*MAX_COLS cells
// (16000 at the defaults); req_tready stays low during that sweep. Commands
// enter a two-beat queue and are executed one at a time by the back end, which
// owns the single-write-port screen RAM. Set cursor, bell, backspace, carriage
// return, line feed and printable characters without scroll, bad opcodes, bad
// pages and rejected windows go from the queue via the idle, execute and done
// states to the result register; a cell read also passes read wait. A window
// scroll writes each filled cell and reads, then writes, each copied cell; a
// teletype page scroll walks all C*R cells the same way. The result register
// lets the next command run while a result waits on rsp_tready.
module text_mode_screen_engine #(
   parameter int MAX_COLS = tmse_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tmse_pkg::MAX_ROWS_DEF,
   parameter int PAGES    = tmse_pkg::PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,  // 0 columns_in_use, 1 rows_in_use
   input  logic [tmse_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [2:0]                      req_tuser,  // opcode
   // page, char_code, attr, cursor_col_in, cursor_row_in, line_count,
   // win_left, top_row, win_right, bottom_row
   input  logic [tmse_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_tuser,  // status
   // cell_char, cell_attr, cursor_col_out, cursor_row_out, scrolled
   output logic [tmse_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tmse_pkg::*;
   `include "text_mode_screen_engine_defines.svh"

   logic    clearing, q_full, q_push, q_empty, q_pop;
   cmd_type q_in_cmd, q_out_cmd;
   res_type res;

   tmse_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .PAGES(PAGES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   tmse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (q_out_cmd)
   );

   tmse_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .PAGES(PAGES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_out_cmd),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_res   (res)
   );

   // pack the result beat
   assign rsp_tdata = {3'b000, res.scrolled, res.row, res.col, res.cell_attr, res.cell_char};
   assign rsp_tuser = res.status;

   `TMSE_ASSERT_IMPL(a_no_intake_while_clearing, clock, reset, clearing, !req_tready)
   `TMSE_ASSERT_IMPL(a_reject_no_cell, clock, reset, rsp_tvalid && (rsp_tuser == ST_REJECT), rsp_tdata[15:0] == 16'h0000)
   `TMSE_ASSERT_IMPL(a_scroll_only_done, clock, reset, rsp_tvalid && rsp_tdata[28], rsp_tuser == ST_DONE)
   `TMSE_ASSERT_NEXT(a_pop_runs_command, clock, reset, q_pop, !q_pop && !clearing)
endmodule
